FILE: src/tlre_pkg.sv
// tlre_pkg: shared types and constants for the tank level rate estimator
// no dependencies
package tlre_pkg;

    localparam int unsigned FULL_FINE = 25600;
    localparam int unsigned MIN_DT_MS = 30000;

    // reciprocals for the constant divisions, exact for 32-bit dividends
    // x / 100 = (x * RECIP_100) >> 37, x / 5 = (x * RECIP_5) >> 34
    localparam logic [31:0] RECIP_100 = 32'h51EB_851F;
    localparam logic [31:0] RECIP_5   = 32'hCCCC_CCCD;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_FAULT  = 2'd1;
    localparam logic [1:0] ERR_UNCONF = 2'd2;

    localparam logic [2:0] REG_HEIGHT = 3'd0;
    localparam logic [2:0] REG_BLIND  = 3'd1;
    localparam logic [2:0] REG_CAP    = 3'd2;
    localparam logic [2:0] REG_GEOM   = 3'd3;
    localparam logic [2:0] REG_AGE    = 3'd4;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

endpackage

FILE: src/tlre_div.sv
// tlre_div: shared restoring divider, one quotient bit per cycle
// depends on tlre_pkg
module tlre_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  tlre_pkg::div_req_t req,
    output tlre_pkg::div_rsp_t rsp
);
    import tlre_pkg::*;

    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[31:0], quo_reg[63]} - {1'b0, dvs_reg};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[31:0], quo_reg[63]};
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule

FILE: src/tank_level_rate_estimator_core.sv
// tank_level_rate_estimator_core: top level, sequencer, ring and register file
// depends on tlre_pkg and tlre_div
//
// channel | direction | handshake       | content
// in      | in        | in_valid/ready  | distance, fault, flow, timestamp
// out     | out       | out_valid/ready | level, volume, inflow, eta, rate
// cfg     | in        | apb psel/penable| five geometry and history registers
//
// an error word goes from the check state straight to the output state
// a good word passes through, as needed, level, rate and eta divisions on the
// shared divider, a ring scan of up to HISTORY_DEPTH entries, volume, inflow
// and the eta check, then the output state
// reset clears used marks, head, held values; ring payload is not cleared
// a finished word waits in the output register; the next input is taken
// once it has been taken
module tank_level_rate_estimator_core
#(
    parameter int HISTORY_DEPTH = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] distance_tenth_cm,
    input  logic        sensor_fault,
    input  logic        flow_on,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        accepted,
    output logic [1:0]  error_code,
    output logic [6:0]  level_percent,
    output logic [14:0] level_fine,
    output logic [19:0] volume_liters,
    output logic [24:0] inflow_tenth_lpm,
    output logic [17:0] eta_seconds,
    output logic        filling,
    output logic signed [16:0] rate_fine
);
    import tlre_pkg::*;

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_CHECK = 12'b000000000010,
        S_LVLW  = 12'b000000000100,
        S_SCAN  = 12'b000000001000,
        S_RATEW = 12'b000000010000,
        S_VOLM  = 12'b000000100000,
        S_VOLR  = 12'b000001000000,
        S_INFM  = 12'b000010000000,
        S_INFR  = 12'b000100000000,
        S_ETA   = 12'b001000000000,
        S_ETAW  = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [9:0]  height_reg;
    logic [7:0]  blind_reg;
    logic [19:0] cap_reg;
    logic        geom_reg;
    logic [26:0] age_reg;
    logic        wr_en;
    logic [2:0]  wr_idx;
    logic        clr_ring;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = paddr[4:2];
    assign clr_ring = wr_en && (wr_idx == REG_HEIGHT || wr_idx == REG_BLIND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= '0;
            blind_reg  <= '0;
            cap_reg    <= '0;
            geom_reg   <= 1'b0;
            age_reg    <= 27'd900000;
        end
        else if (wr_en)
        begin
            case (wr_idx)
                REG_HEIGHT: height_reg <= pwdata[9:0];
                REG_BLIND:  blind_reg  <= pwdata[7:0];
                REG_CAP:    cap_reg    <= pwdata[19:0];
                REG_GEOM:   geom_reg   <= pwdata[0];
                REG_AGE:    age_reg    <= pwdata[26:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (wr_idx)
            REG_HEIGHT: prdata = {22'd0, height_reg};
            REG_BLIND:  prdata = {24'd0, blind_reg};
            REG_CAP:    prdata = {12'd0, cap_reg};
            REG_GEOM:   prdata = {31'd0, geom_reg};
            REG_AGE:    prdata = {5'd0, age_reg};
            default:    prdata = '0;
        endcase
    end

    // history ring: small, scanned one entry per cycle
    logic [31:0] htime_reg [HISTORY_DEPTH];
    logic [14:0] hlvl_reg  [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] used_reg;
    logic [AW-1:0] head_reg;

    // captured input word
    logic [15:0] dist_reg;
    logic        fault_reg, flow_reg;
    logic [31:0] now_reg;

    // working values
    logic [1:0]  err_reg;
    logic [14:0] lvl_reg, held_lvl_reg;
    logic [19:0] held_vol_reg;
    logic [24:0] held_inf_reg;
    logic [17:0] held_eta_reg;
    logic signed [16:0] rate_reg;
    logic [AW:0] scan_cnt_reg;
    logic [AW-1:0] scan_idx;
    logic        rate_neg_reg;
    logic [35:0] prod_reg;
    logic        push;

    div_req_t dreq;
    div_rsp_t drsp;

    tlre_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // level numerator
    logic signed [18:0] lvl_num;
    assign lvl_num = $signed({9'd0, height_reg}) * 19'sd10
        + $signed({11'd0, blind_reg}) * 19'sd10 - $signed({3'd0, dist_reg});
    logic [13:0] h10;
    assign h10 = 14'(height_reg) * 14'd10;

    // scan entry
    logic [AW:0] idx_sum;
    logic [31:0] dt_scan;
    always_comb
    begin
        idx_sum = {1'b0, head_reg} + scan_cnt_reg;
        if (idx_sum >= (AW+1)'(HISTORY_DEPTH))
            idx_sum = idx_sum - (AW+1)'(HISTORY_DEPTH);
        scan_idx = idx_sum[AW-1:0];
        dt_scan  = now_reg - htime_reg[scan_idx];
    end

    logic [14:0] diff_abs;
    always_comb
    begin
        if (lvl_reg >= hlvl_reg[scan_idx])
            diff_abs = lvl_reg - hlvl_reg[scan_idx];
        else
            diff_abs = hlvl_reg[scan_idx] - lvl_reg;
    end

    logic [17:0] rem_lvl;
    assign rem_lvl = 18'(FULL_FINE) - 18'(lvl_reg);
    logic [15:0] rate_pos;
    assign rate_pos = rate_reg[15:0];

    // volume and inflow: capacity product, then constant division by
    // shift and reciprocal multiply on the next cycle
    logic [15:0] mul_b;
    logic [35:0] prod_small;
    logic [26:0] rcp_a;
    logic [31:0] rcp_k;
    logic [58:0] rcp_prod;
    assign mul_b      = (state_reg == S_INFM) ? rate_pos : 16'(lvl_reg);
    assign prod_small = 36'(cap_reg) * 36'(mul_b);
    assign rcp_a      = (state_reg == S_INFR) ? prod_reg[35:9] : prod_reg[34:8];
    assign rcp_k      = (state_reg == S_INFR) ? RECIP_5 : RECIP_100;
    assign rcp_prod   = 59'(rcp_a) * 59'(rcp_k);

    always_comb
    begin
        state_next = state_reg;
        dreq = '0;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_CHECK;
            S_CHECK:
            begin
                if (fault_reg || !geom_reg || height_reg == '0 || cap_reg == '0)
                    state_next = S_OUT;
                else if (lvl_num <= 0 || lvl_num >= $signed({5'd0, h10}))
                    state_next = S_SCAN;
                else
                begin
                    dreq.start    = 1'b1;
                    dreq.dividend = 64'(lvl_num[16:0]) * 64'd2560;
                    dreq.divisor  = 32'(height_reg);
                    state_next    = S_LVLW;
                end
            end
            S_LVLW:  if (drsp.done) state_next = S_SCAN;
            S_SCAN:
            begin
                if (scan_cnt_reg == (AW+1)'(HISTORY_DEPTH))
                    state_next = S_VOLM;
                else if (used_reg[scan_idx] && dt_scan <= 32'(age_reg))
                begin
                    if (dt_scan < MIN_DT_MS)
                        state_next = S_VOLM;
                    else
                    begin
                        dreq.start    = 1'b1;
                        dreq.dividend = 64'(diff_abs) * 64'd60000;
                        dreq.divisor  = dt_scan;
                        state_next    = S_RATEW;
                    end
                end
            end
            S_RATEW: if (drsp.done) state_next = S_VOLM;
            S_VOLM:  state_next = S_VOLR;
            S_VOLR:
            begin
                if (!rate_reg[16] && rate_reg != '0)
                    state_next = S_INFM;
                else
                    state_next = S_ETA;
            end
            S_INFM:  state_next = S_INFR;
            S_INFR:  state_next = S_ETA;
            S_ETA:
            begin
                if (flow_reg && !rate_reg[16] && rate_reg >= 17'sd3
                    && lvl_reg < 15'(FULL_FINE)
                    && 32'(rem_lvl) < 32'(rate_pos) * 32'd2880)
                begin
                    dreq.start    = 1'b1;
                    dreq.dividend = 64'(rem_lvl) * 64'd60;
                    dreq.divisor  = 32'(rate_pos);
                    state_next    = S_ETAW;
                end
                else
                    state_next = S_OUT;
            end
            S_ETAW:  if (drsp.done) state_next = S_OUT;
            S_OUT:   if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // level goes into the ring as the scan ends
    assign push = (state_reg == S_SCAN) && (state_next != S_SCAN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            used_reg     <= '0;
            head_reg     <= '0;
            held_lvl_reg <= '0;
            held_vol_reg <= '0;
            held_inf_reg <= '0;
            held_eta_reg <= '0;
            scan_cnt_reg <= '0;
            rate_reg     <= '0;
            rate_neg_reg <= 1'b0;
            lvl_reg      <= '0;
            prod_reg     <= '0;
            err_reg      <= ERR_NONE;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_ring)
            begin
                used_reg <= '0;
                head_reg <= '0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    rate_reg     <= '0;
                    scan_cnt_reg <= '0;
                    err_reg      <= ERR_NONE;
                end
                S_CHECK:
                begin
                    if (fault_reg)
                        err_reg <= ERR_FAULT;
                    else if (!geom_reg || height_reg == '0 || cap_reg == '0)
                        err_reg <= ERR_UNCONF;
                    else if (lvl_num <= 0)
                        lvl_reg <= '0;
                    else if (lvl_num >= $signed({5'd0, h10}))
                        lvl_reg <= 15'(FULL_FINE);
                end
                S_LVLW: if (drsp.done) lvl_reg <= drsp.quotient[14:0];
                S_SCAN:
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    rate_neg_reg <= lvl_reg < hlvl_reg[scan_idx];
                    if (push)
                    begin
                        used_reg[head_reg]  <= 1'b1;
                        head_reg <= (head_reg == AW'(HISTORY_DEPTH - 1)) ? '0
                                    : head_reg + 1'b1;
                        held_lvl_reg <= lvl_reg;
                        held_inf_reg <= '0;
                        held_eta_reg <= '0;
                    end
                end
                S_RATEW:
                    if (drsp.done)
                        rate_reg <= rate_neg_reg ? -$signed(17'(drsp.quotient[16:0]))
                                    : $signed(17'(drsp.quotient[16:0]));
                S_VOLM:  prod_reg <= prod_small;
                S_VOLR:  held_vol_reg <= rcp_prod[56:37];
                S_INFM:  prod_reg <= prod_small;
                S_INFR:  held_inf_reg <= rcp_prod[58:34];
                S_ETAW:  if (drsp.done) held_eta_reg <= drsp.quotient[17:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            dist_reg  <= distance_tenth_cm;
            fault_reg <= sensor_fault;
            flow_reg  <= flow_on;
            now_reg   <= now_ms;
        end
        if (push)
        begin
            htime_reg[head_reg] <= now_reg;
            hlvl_reg[head_reg]  <= lvl_reg;
        end
    end

    assign in_ready         = (state_reg == S_IDLE);
    assign out_valid        = (state_reg == S_OUT);
    assign accepted         = (err_reg == ERR_NONE);
    assign error_code       = err_reg;
    assign level_fine       = held_lvl_reg;
    assign level_percent    = 7'((16'(held_lvl_reg) + 16'd128) >> 8);
    assign volume_liters    = held_vol_reg;
    assign inflow_tenth_lpm = held_inf_reg;
    assign eta_seconds      = held_eta_reg;
    assign filling          = flow_reg;
    assign rate_fine        = rate_reg;

    // output word only while no input is taken
    assert property (@(posedge clk) disable iff (!rst_n) !(out_valid && in_ready))
        else $error("in and out both open");
    // error word carries no rate
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error_code != ERR_NONE) |-> rate_fine == '0)
        else $error("rate on error");
    // level never beyond full
    assert property (@(posedge clk) disable iff (!rst_n)
        level_fine <= 15'(FULL_FINE))
        else $error("level above full");
    // a held word stays until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(level_fine))
        else $error("output dropped");
endmodule

FILE: tb/testbench.sv
// testbench for tank_level_rate_estimator_core: random and directed readings,
// apb register setup, self-checking against an in-bench level and rate predictor
// depends on tlre_pkg and the core rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tlre_pkg::*;

    // one reading as it goes into the block
    typedef struct {
        logic [15:0] echo;
        logic        fault;
        logic        flow;
        logic [31:0] stamp;
    } reading_t;

    // one status word as the block reports it
    typedef struct packed {
        logic               acc;
        logic [1:0]         err;
        logic [6:0]         pct;
        logic [14:0]        fine;
        logic [19:0]        vol;
        logic [24:0]        inflow;
        logic [17:0]        eta;
        logic               fill;
        logic signed [16:0] rate;
    } status_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0, in_ready;
    logic [15:0] distance_tenth_cm = '0;
    logic sensor_fault = 1'b0, flow_on = 1'b0;
    logic [31:0] now_ms = '0;
    logic out_valid, out_ready = 1'b0;
    status_t dut_word;

    tank_level_rate_estimator_core u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .distance_tenth_cm(distance_tenth_cm), .sensor_fault(sensor_fault),
        .flow_on(flow_on), .now_ms(now_ms),
        .out_valid(out_valid), .out_ready(out_ready),
        .accepted(dut_word.acc), .error_code(dut_word.err),
        .level_percent(dut_word.pct), .level_fine(dut_word.fine),
        .volume_liters(dut_word.vol), .inflow_tenth_lpm(dut_word.inflow),
        .eta_seconds(dut_word.eta), .filling(dut_word.fill),
        .rate_fine(dut_word.rate)
    );

    always #5 clk = ~clk;

    // predictor copy of the registers
    logic [9:0]  tank_h;
    logic [7:0]  blind_b;
    logic [19:0] cap_l;
    logic        geom_ok;
    logic [26:0] max_age;

    // predictor copy of the history ring and held outputs
    logic [31:0] ring_stamp [8];
    logic [14:0] ring_lvl [8];
    logic        ring_used [8];
    int          ring_head;
    logic [14:0] hold_fine;
    logic [19:0] hold_vol;
    logic [24:0] hold_inflow;
    logic [17:0] hold_eta;

    reading_t pending_q[$];
    status_t  status_q[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int words_in = 0, words_out = 0, accepted_cnt = 0, rising_cnt = 0;
    longint cycles = 0;
    bit in_fired = 1'b0;

    // stimulus walk state
    logic [31:0] walk_ms;
    int walk_dist;

    function automatic void clear_history();
        for (int i = 0; i < 8; i++)
            ring_used[i] = 1'b0;
        ring_head = 0;
    endfunction

    // level, ring lookup and derived outputs for one accepted reading
    function automatic status_t predict_status(reading_t r);
        status_t s;
        logic [1:0] e;
        longint num, lvl, rate, remain;
        logic [31:0] dt;
        int k;
        bit found;
        e = ERR_NONE;
        rate = 0;
        if (r.fault)
            e = ERR_FAULT;
        else if (!geom_ok || tank_h == 0 || cap_l == 0)
            e = ERR_UNCONF;
        if (e == ERR_NONE) begin
            num = 10 * longint'(tank_h) + 10 * longint'(blind_b) - longint'(r.echo);
            if (num <= 0)
                lvl = 0;
            else if (num >= 10 * longint'(tank_h))
                lvl = FULL_FINE;
            else
                lvl = (2560 * num) / longint'(tank_h);
            // oldest fresh entry wins, too-recent one gives no rate
            found = 1'b0;
            for (int i = 0; i < 8; i++) begin
                k = (ring_head + i) % 8;
                if (!found && ring_used[k]) begin
                    dt = r.stamp - ring_stamp[k];
                    if (dt <= {5'b0, max_age}) begin
                        found = 1'b1;
                        if (dt >= MIN_DT_MS)
                            rate = ((lvl - longint'(ring_lvl[k])) * 60000) / longint'(dt);
                    end
                end
            end
            ring_stamp[ring_head] = r.stamp;
            ring_lvl[ring_head] = lvl[14:0];
            ring_used[ring_head] = 1'b1;
            ring_head = (ring_head + 1) % 8;
            hold_fine = lvl[14:0];
            hold_vol = 20'((longint'(cap_l) * lvl) / FULL_FINE);
            hold_inflow = (rate > 0) ? 25'((longint'(cap_l) * rate) / 2560) : '0;
            hold_eta = '0;
            if (r.flow && rate >= 3 && lvl < FULL_FINE) begin
                remain = FULL_FINE - lvl;
                if (remain < 2880 * rate)
                    hold_eta = 18'((remain * 60) / rate);
            end
        end
        s.acc = (e == ERR_NONE);
        s.err = e;
        s.pct = 7'((32'(hold_fine) + 128) >> 8);
        s.fine = hold_fine;
        s.vol = hold_vol;
        s.inflow = hold_inflow;
        s.eta = hold_eta;
        s.fill = r.flow;
        s.rate = 17'(rate);
        return s;
    endfunction

    // apb write: setup cycle then access cycle, mirror updated alongside
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_HEIGHT: begin tank_h = val[9:0]; clear_history(); end
            REG_BLIND:  begin blind_b = val[7:0]; clear_history(); end
            REG_CAP:    cap_l = val[19:0];
            REG_GEOM:   geom_ok = val[0];
            REG_AGE:    max_age = val[26:0];
            default: ;
        endcase
    endtask

    task automatic load_tank(int h, int b, int c, int g, int age);
        reg_write(REG_HEIGHT, 32'(h));
        reg_write(REG_BLIND, 32'(b));
        reg_write(REG_CAP, 32'(c));
        reg_write(REG_GEOM, 32'(g));
        reg_write(REG_AGE, 32'(age));
        walk_dist = 10 * (h + b);
    endtask

    task automatic add_reading(int d, bit f, bit fl, logic [31:0] t);
        reading_t r;
        r.echo = 16'(d);
        r.fault = f;
        r.flow = fl;
        r.stamp = t;
        pending_q.push_back(r);
    endtask

    // mostly a filling tank sampled every half minute to few minutes,
    // with faults, short gaps, long gaps, timestamp jumps and wild distances
    task automatic add_random_readings(int count);
        int pick, lo, hi;
        reading_t r;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                walk_ms += $urandom_range(30000, 150000);
            else if (pick < 85)
                walk_ms += $urandom_range(0, 29999);
            else if (pick < 95)
                walk_ms += $urandom_range(150000, 3000000);
            else
                walk_ms = $urandom;
            lo = 10 * int'(blind_b);
            hi = 10 * (int'(tank_h) + int'(blind_b));
            walk_dist -= $urandom_range(0, 60);
            if ($urandom_range(0, 19) == 0)
                walk_dist += $urandom_range(0, 400);
            if (walk_dist < lo - 30 || walk_dist > hi + 30)
                walk_dist = $urandom_range(lo, hi + 30);
            if (walk_dist < 0)
                walk_dist = 0;
            r.echo = ($urandom_range(0, 99) < 85) ? 16'(walk_dist) : 16'($urandom);
            r.fault = ($urandom_range(0, 99) < 8);
            r.flow = ($urandom_range(0, 99) < 80);
            r.stamp = walk_ms;
            pending_q.push_back(r);
        end
    endtask

    // block until every queued word is in and every status word is out
    task automatic drain();
        while (pending_q.size() != 0 || in_valid || status_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // input acceptance: predict on the edge the word is taken
    always @(posedge clk) begin
        cycles++;
        in_fired = in_valid && in_ready;
        if (in_fired) begin
            status_q.push_back(predict_status('{distance_tenth_cm, sensor_fault,
                                                 flow_on, now_ms}));
            words_in++;
        end
    end

    // output monitor: compare each status word with the oldest prediction
    always @(posedge clk) begin
        status_t want;
        if (out_valid && out_ready) begin
            words_out++;
            if (dut_word.acc)
                accepted_cnt++;
            if (dut_word.acc && dut_word.rate > 0)
                rising_cnt++;
            if (status_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected status word %p", dut_word);
            end else begin
                want = status_q.pop_front();
                if (want !== dut_word) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, dut_word);
                end
            end
        end
    end

    // driver: new word at the falling edge once the previous one is taken
    always @(negedge clk) begin
        reading_t r;
        if (rst_n) begin
            if (!in_valid || in_fired) begin
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    r = pending_q.pop_front();
                    distance_tenth_cm <= r.echo;
                    sensor_fault <= r.fault;
                    flow_on <= r.flow;
                    now_ms <= r.stamp;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk) begin
        if (cycles > 3000000) begin
            $display("timeout with %0d status words still expected", status_q.size());
            $display("FAIL tank_level_rate_estimator_core");
            $finish;
        end
    end

    initial begin
        int idle_mode;
        tank_h = '0;
        blind_b = '0;
        cap_l = '0;
        geom_ok = 1'b0;
        max_age = 27'd900000;
        clear_history();
        hold_fine = '0;
        hold_vol = '0;
        hold_inflow = '0;
        hold_eta = '0;
        walk_ms = 32'd0;
        walk_dist = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // unconfigured after reset, and fault takes priority
        add_reading(1000, 1'b0, 1'b1, 32'd0);
        add_reading(0, 1'b1, 1'b0, 32'd1000);
        drain();

        // extremes of geometry, capacity and age
        load_tank(1023, 255, 1048575, 1, 86400000);
        add_reading(65535, 1'b0, 1'b1, 32'hFFFF_0000);   // empty
        add_reading(0, 1'b0, 1'b1, 32'hFFFF_9000);       // full, timestamp wraps next
        add_reading(12780, 1'b0, 1'b1, 32'h0000_2000);   // drop with wrapped dt
        add_reading(12000, 1'b0, 1'b1, 32'h0000_3000);   // soon after the last, rate from the oldest
        add_reading(11000, 1'b1, 1'b1, 32'h0001_0000);   // fault keeps held values
        add_reading(5000, 1'b0, 1'b0, 32'h0002_0000);    // rising, flow off
        add_reading(2550, 1'b0, 1'b1, 32'h0003_0000);    // exactly at blind zone
        drain();

        // tiny tank, zero blind, short age so entries go stale
        load_tank(1, 0, 1, 1, 40000);
        add_reading(10, 1'b0, 1'b1, 32'd0);
        add_reading(5, 1'b0, 1'b1, 32'd35000);
        add_reading(0, 1'b0, 1'b1, 32'd100000);          // only stale entries
        add_reading(9, 1'b0, 1'b1, 32'd100100);
        drain();

        // zero age, zero capacity, and geometry flag off
        load_tank(300, 25, 5000, 1, 0);
        add_reading(2000, 1'b0, 1'b1, 32'd0);
        add_reading(1800, 1'b0, 1'b1, 32'd60000);
        drain();
        reg_write(REG_CAP, 32'd0);
        add_reading(1800, 1'b0, 1'b1, 32'd120000);
        drain();
        reg_write(REG_CAP, 32'hFFF0_1388);              // upper bits masked
        reg_write(REG_GEOM, 32'd0);
        add_reading(1700, 1'b0, 1'b1, 32'd180000);
        drain();

        // random phases across idling patterns and tank setups
        for (int p = 0; p < 8; p++) begin
            idle_mode = p % 4;
            send_idle_pct = (idle_mode == 1 || idle_mode == 3) ? 46 : 0;
            recv_stall_pct = (idle_mode == 2 || idle_mode == 3) ? 46 : 0;
            if (idle_mode == 3) begin
                send_idle_pct = 24;
                recv_stall_pct = 24;
            end
            case (p)
                0: load_tank(300, 25, 5000, 1, 900000);
                1: load_tank(1023, 255, 1048575, 1, 86400000);
                2: load_tank(1, 0, 1, 1, 60000);
                3: load_tank(150, 10, 200, 1, 300000);
                4: load_tank($urandom_range(1, 1023), $urandom_range(0, 255),
                             $urandom_range(1, 1048575), 1, $urandom_range(30000, 2000000));
                5: load_tank(500, 40, 20000, ($urandom_range(0, 3) != 0), 900000);
                6: load_tank(80, 200, 999999, 1, 0);
                default: load_tank(700, 128, 65536, 1, 134217727);
            endcase
            add_random_readings(230);
            drain();
        end

        $display("covered %0d readings over directed setups and 8 random phases, %0d accepted, %0d with a rising rate",
                 words_in, accepted_cnt, rising_cnt);
        $display("%0d status words checked, %0d mismatches", words_out, mismatches);
        if (mismatches == 0 && status_q.size() == 0)
            $display("PASS tank_level_rate_estimator_core");
        else
            $display("FAIL tank_level_rate_estimator_core");
        $finish;
    end
endmodule
